/* rtl/sv39_page_table_map_and_walk_macros.svh */
// Assertion macros used by the datapath of the Sv39 page-table engine.
// Depends on nothing; defining NO_ASSERTIONS turns every check into nothing.
`ifndef SV39_PAGE_TABLE_MAP_AND_WALK_MACROS_SVH
`define SV39_PAGE_TABLE_MAP_AND_WALK_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication check: whenever ante holds at an edge, cons holds at that edge.
`define SV39_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sv39 page table engine: implication check failed");

// Invariant check: expr holds at every edge outside reset.
`define SV39_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("sv39 page table engine: invariant check failed");

`else

`define SV39_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define SV39_ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`endif

`endif

/* rtl/sv39_ptw_pkg.sv */
// Package of the Sv39 page-table engine: sizes, word types, codes and the
// controller/datapath command and status structs. Depends on nothing.
`default_nettype none

package sv39_ptw_pkg;

	localparam int NUM_TABLES        = 64;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int VPN_W             = $clog2(ENTRIES_PER_TABLE);
	localparam int SLOT_W            = $clog2(NUM_TABLES);
	localparam int USED_W            = $clog2(NUM_TABLES + 1);
	localparam int ADDR_W            = SLOT_W + VPN_W;
	localparam int MEM_DEPTH         = NUM_TABLES * ENTRIES_PER_TABLE;
	localparam int PPN_W             = 44;
	localparam int ENT_W             = 54;
	localparam int VA_W              = 39;
	localparam int PA_W              = 56;
	localparam int FLAGS_W           = 8;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		LVL0 = 2'd0,
		LVL1 = 2'd1,
		LVL2 = 2'd2
	} lvl_t;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_MAP    = 1'b1
	} action_t;

	typedef struct packed {
		logic               action;
		logic [VA_W-1:0]    virt_addr;
		logic [PA_W-1:0]    phys_addr;
		logic [FLAGS_W-1:0] perm_flags;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ENT_W-1:0]   entry;
	} rsp_t;

	// Write port source of the table store.
	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_CLR  = 2'd1,
		WR_PTR  = 2'd2,
		WR_LEAF = 2'd3
	} wr_sel_t;

	// Source of the entry field of a result.
	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_RDATA = 2'd1,
		RES_LEAF  = 2'd2
	} res_src_t;

	typedef struct packed {
		logic     load;     // latch the accepted word, reset the walk slot
		lvl_t     lvl;      // level whose entry is being checked
		logic     adv;      // descend: take the next slot, read the next level
		logic     alloc;    // take a fresh slot and link it
		wr_sel_t  wr_sel;
		logic     set_res;  // capture the pending result
		status_t  res_st;
		res_src_t res_src;
		logic     push;     // move the pending result into the output register
	} cmd_t;

	typedef struct packed {
		logic clr_last;  // last entry of the clearing pass is being written
		logic ent_v;     // V bit of the entry just read
		logic ptr_ok;    // that entry points at a slot already in use
		logic full;      // every slot is taken
		logic is_map;    // the word in progress is a map
		logic out_free;  // the output register can take a result this cycle
	} sts_t;

	function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va, input lvl_t lvl);
		logic [VPN_W-1:0] v;
		case (lvl)
			LVL2:    v = va[38:30];
			LVL1:    v = va[29:21];
			LVL0:    v = va[20:12];
			default: v = va[20:12];
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/sv39_ptw_ctrl.sv */
// Walk controller of the Sv39 page-table engine: one-hot state machine that
// sequences clearing, table reads, allocation and result hand-off. Uses sv39_ptw_pkg.
`default_nettype none

module sv39_ptw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sv39_ptw_pkg::sts_t sts,
	output sv39_ptw_pkg::cmd_t     cmd
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_CHK2  = 7'b0000100,
		S_CHK1  = 7'b0001000,
		S_CHK0  = 7'b0010000,
		S_WR0   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.lvl     = sv39_ptw_pkg::LVL2;
		cmd.wr_sel  = sv39_ptw_pkg::WR_NONE;
		cmd.res_st  = sv39_ptw_pkg::ST_OK;
		cmd.res_src = sv39_ptw_pkg::RES_ZERO;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_sel = sv39_ptw_pkg::WR_CLR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK2;
				end
			end
			S_CHK2, S_CHK1: begin
				cmd.lvl = (state_q == S_CHK2) ? sv39_ptw_pkg::LVL2 : sv39_ptw_pkg::LVL1;
				if (sts.ent_v && !sts.ptr_ok) begin
					// A valid pointer to a slot that is not in use ends the walk.
					cmd.set_res = 1'b1;
					cmd.res_st  = sts.is_map ? sv39_ptw_pkg::ST_FULL : sv39_ptw_pkg::ST_MISS;
					state_d     = S_DONE;
				end else if (!sts.ent_v && !sts.is_map) begin
					cmd.set_res = 1'b1;
					cmd.res_st  = sv39_ptw_pkg::ST_MISS;
					state_d     = S_DONE;
				end else if (!sts.ent_v && sts.full) begin
					cmd.set_res = 1'b1;
					cmd.res_st  = sv39_ptw_pkg::ST_FULL;
					state_d     = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					if (!sts.ent_v) begin
						cmd.alloc  = 1'b1;
						cmd.wr_sel = sv39_ptw_pkg::WR_PTR;
					end
					if (state_q == S_CHK2) begin
						state_d = S_CHK1;
					end else if (sts.is_map) begin
						state_d = S_WR0;
					end else begin
						state_d = S_CHK0;
					end
				end
			end
			S_CHK0: begin
				cmd.lvl     = sv39_ptw_pkg::LVL0;
				cmd.set_res = 1'b1;
				cmd.res_src = sv39_ptw_pkg::RES_RDATA;
				state_d     = S_DONE;
			end
			S_WR0: begin
				cmd.lvl     = sv39_ptw_pkg::LVL0;
				cmd.wr_sel  = sv39_ptw_pkg::WR_LEAF;
				cmd.set_res = 1'b1;
				cmd.res_src = sv39_ptw_pkg::RES_LEAF;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/sv39_ptw_dp.sv */
// Datapath of the Sv39 page-table engine: table store, slot counter, base
// register, walk registers and output register. Uses sv39_ptw_pkg and the macros header.
`default_nettype none
`include "sv39_page_table_map_and_walk_macros.svh"

module sv39_ptw_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sv39_ptw_pkg::req_t                in_data,
	input  wire logic                              cfg_we,
	input  wire logic [sv39_ptw_pkg::PPN_W-1:0]    cfg_data,
	input  wire sv39_ptw_pkg::cmd_t                cmd,
	output sv39_ptw_pkg::sts_t                     sts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output sv39_ptw_pkg::rsp_t                     out_data
);

	logic [sv39_ptw_pkg::ENT_W-1:0]  store_q [sv39_ptw_pkg::MEM_DEPTH];
	logic [sv39_ptw_pkg::ENT_W-1:0]  rd_q;
	logic [sv39_ptw_pkg::ADDR_W-1:0] clr_cnt_q;
	logic [sv39_ptw_pkg::USED_W-1:0] used_q;
	logic [sv39_ptw_pkg::PPN_W-1:0]  base_q;
	logic [sv39_ptw_pkg::SLOT_W-1:0] slot_q;
	sv39_ptw_pkg::req_t              item_q;
	sv39_ptw_pkg::rsp_t              rslt_q;
	sv39_ptw_pkg::rsp_t              out_q;
	logic                            out_valid_q;

	logic [sv39_ptw_pkg::PPN_W-1:0]  off;
	logic [sv39_ptw_pkg::SLOT_W-1:0] slot_d;
	logic [sv39_ptw_pkg::ADDR_W-1:0] rd_addr;
	logic [sv39_ptw_pkg::ADDR_W-1:0] wr_addr;
	logic [sv39_ptw_pkg::ENT_W-1:0]  wr_data;
	logic [sv39_ptw_pkg::ENT_W-1:0]  ptr_ent;
	logic [sv39_ptw_pkg::ENT_W-1:0]  leaf_ent;
	logic                            wr_en;
	sv39_ptw_pkg::lvl_t              next_lvl;

	// Offset of the pointed-to table from slot zero, modulo 2^44.
	assign off    = rd_q[sv39_ptw_pkg::ENT_W-1:10] - base_q;
	assign slot_d = rd_q[0] ? off[sv39_ptw_pkg::SLOT_W-1:0]
	                        : used_q[sv39_ptw_pkg::SLOT_W-1:0];

	assign ptr_ent  = {base_q + sv39_ptw_pkg::PPN_W'(used_q[sv39_ptw_pkg::SLOT_W-1:0]),
	                   9'd0, 1'b1};
	assign leaf_ent = {item_q.phys_addr[sv39_ptw_pkg::PA_W-1:12], 2'b00,
	                   item_q.perm_flags[sv39_ptw_pkg::FLAGS_W-1:1], 1'b1};

	assign next_lvl = (cmd.lvl == sv39_ptw_pkg::LVL2) ? sv39_ptw_pkg::LVL1 : sv39_ptw_pkg::LVL0;

	always_comb begin
		if (cmd.load || !cmd.adv) begin
			rd_addr = {sv39_ptw_pkg::SLOT_W'(0), sv39_ptw_pkg::vpn_of(in_data.virt_addr,
			           sv39_ptw_pkg::LVL2)};
		end else begin
			rd_addr = {slot_d, sv39_ptw_pkg::vpn_of(item_q.virt_addr, next_lvl)};
		end
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = {slot_q, sv39_ptw_pkg::vpn_of(item_q.virt_addr, cmd.lvl)};
		wr_data = '0;
		case (cmd.wr_sel)
			sv39_ptw_pkg::WR_CLR: begin
				wr_addr = clr_cnt_q;
			end
			sv39_ptw_pkg::WR_PTR: begin
				wr_data = ptr_ent;
			end
			sv39_ptw_pkg::WR_LEAF: begin
				wr_data = leaf_ent;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			used_q      <= sv39_ptw_pkg::USED_W'(1);
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_sel == sv39_ptw_pkg::WR_CLR) begin
				clr_cnt_q <= clr_cnt_q + sv39_ptw_pkg::ADDR_W'(1);
			end
			if (cmd.alloc) begin
				used_q <= used_q + sv39_ptw_pkg::USED_W'(1);
			end
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			slot_q <= '0;
		end else if (cmd.adv) begin
			slot_q <= slot_d;
		end
		if (cmd.set_res) begin
			rslt_q.status <= cmd.res_st;
			case (cmd.res_src)
				sv39_ptw_pkg::RES_RDATA: rslt_q.entry <= rd_q;
				sv39_ptw_pkg::RES_LEAF:  rslt_q.entry <= leaf_ent;
				default:                 rslt_q.entry <= '0;
			endcase
		end
		if (cmd.push) begin
			out_q <= rslt_q;
		end
	end

	assign sts.clr_last = &clr_cnt_q;
	assign sts.ent_v    = rd_q[0];
	assign sts.ptr_ok   = off < sv39_ptw_pkg::PPN_W'(used_q);
	assign sts.full     = used_q >= sv39_ptw_pkg::USED_W'(sv39_ptw_pkg::NUM_TABLES);
	assign sts.is_map   = (item_q.action == sv39_ptw_pkg::ACT_MAP);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SV39_ASSERT_IMP(a_alloc_room, clk, arst_n, cmd.wr_sel == sv39_ptw_pkg::WR_PTR, used_q < sv39_ptw_pkg::USED_W'(sv39_ptw_pkg::NUM_TABLES))
	`SV39_ASSERT_ALWAYS(a_used_range, clk, arst_n, (used_q != '0) && (used_q <= sv39_ptw_pkg::USED_W'(sv39_ptw_pkg::NUM_TABLES)))
	`SV39_ASSERT_IMP(a_push_room, clk, arst_n, cmd.push, !out_valid_q || out_ready)

endmodule

`default_nettype wire

/* rtl/sv39_page_table_map_and_walk.sv */
// Top level of the Sv39 page-table map and walk engine.
// Depends on sv39_ptw_pkg, sv39_ptw_ctrl and sv39_ptw_dp.
//
//   channel   direction   word                       accepted when
//   in        input       sv39_ptw_pkg::req_t        in_valid & in_ready
//   out       output      sv39_ptw_pkg::rsp_t        out_valid & out_ready
//   cfg       input       table_base_ppn (44 bits)   cfg_valid & cfg_ready
//
// After reset the table store is swept to zero, one entry per cycle, through all
// NUM_TABLES * 512 entries (32768 with 64 tables); in_ready stays low meanwhile.
// From acceptance to a result in the output register, a word steps through the
// chain of dependent reads of the single-read-port table store: root entry,
// level-1 entry, then the leaf read (lookup) or leaf write (map).
// A walk that stops at an invalid or stray pointer ends before the leaf level.
// The input takes a new word in the cycle after the result is handed to the
// output register, even while that result still waits for out_ready; a stalled
// output holds the next finished result back in the engine.
`default_nettype none

module sv39_page_table_map_and_walk (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire sv39_ptw_pkg::req_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output sv39_ptw_pkg::rsp_t                     out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sv39_ptw_pkg::PPN_W-1:0]    cfg_data
);

	sv39_ptw_pkg::cmd_t cmd;
	sv39_ptw_pkg::sts_t sts;

	// The base register is a plain flop, so a configuration write never stalls.
	assign cfg_ready = 1'b1;

	// The controller only sequences; every register that holds data lives
	// in the datapath, including the table store and the output register.
	sv39_ptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sv39_ptw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* bench/sv39_page_table_map_and_walk_test.sv */
// Self-checking bench for the Sv39 page-table map and walk engine: directed rows, then random phases
// under several table base settings; a shadow table store predicts words that the plan does not fix.
// Depends on sv39_ptw_pkg and sv39_page_table_map_and_walk.
`default_nettype none

module sv39_page_table_map_and_walk_test;

	// Timing of the run. The limit leaves a wide margin over the full sweep of the table
	// store after reset and over the walks of all the words that follow.
	localparam int unsigned LIMIT_CYCLES    = 400000;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned DRAIN_CYCLES    = 20;
	localparam int unsigned ITEMS_PER_PHASE = 255;
	localparam int unsigned PHASES          = 6;
	localparam int unsigned HOLD_AFTER      = 150;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned PLAN_ROWS       = 23;

	// Short local names for the package codes, so that the plan rows stay readable.
	localparam sv39_ptw_pkg::action_t A_LOOKUP = sv39_ptw_pkg::ACT_LOOKUP;
	localparam sv39_ptw_pkg::action_t A_MAP    = sv39_ptw_pkg::ACT_MAP;
	localparam sv39_ptw_pkg::status_t S_OK     = sv39_ptw_pkg::ST_OK;
	localparam sv39_ptw_pkg::status_t S_MISS   = sv39_ptw_pkg::ST_MISS;
	localparam sv39_ptw_pkg::status_t S_FULL   = sv39_ptw_pkg::ST_FULL;

	// Root and middle indices that random words mostly draw from, so that later maps
	// and lookups land in tables that already exist instead of always asking for new ones.
	localparam logic [sv39_ptw_pkg::VPN_W-1:0] ROOT_PICKS [6] =
		'{9'd0, 9'd511, 9'd170, 9'd1, 9'd300, 9'd64};
	localparam logic [sv39_ptw_pkg::VPN_W-1:0] MID_PICKS [4] = '{9'd0, 9'd511, 9'd3, 9'd300};

	typedef enum logic {
		ROW_WORD = 1'b0,
		ROW_BASE = 1'b1
	} row_kind_t;

	// One row of the directed plan. For a ROW_BASE row the pa column carries the new
	// table base. Where fixed is set, st and ent are the result the word must give;
	// elsewhere the shadow store decides.
	typedef struct packed {
		row_kind_t                        kind;
		sv39_ptw_pkg::action_t            act;
		logic [sv39_ptw_pkg::VA_W-1:0]    va;
		logic [sv39_ptw_pkg::PA_W-1:0]    pa;
		logic [7:0]                       flags;
		logic                             fixed;
		sv39_ptw_pkg::status_t            st;
		logic [sv39_ptw_pkg::ENT_W-1:0]   ent;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	sv39_ptw_pkg::req_t in_data;
	logic out_valid;
	logic out_ready;
	sv39_ptw_pkg::rsp_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [sv39_ptw_pkg::PPN_W-1:0] cfg_data;

	// Shadow copy of the engine: its table store, the slot count and the base register.
	logic [sv39_ptw_pkg::ENT_W-1:0] shadow_store [sv39_ptw_pkg::MEM_DEPTH];
	int unsigned                    slots_taken;
	logic [sv39_ptw_pkg::PPN_W-1:0] base_ppn;

	sv39_ptw_pkg::rsp_t            due_results [$];
	logic [sv39_ptw_pkg::VA_W-1:0] mapped_va [$];
	row_t                          plan [PLAN_ROWS];
	int unsigned                   mismatches = 0;
	int unsigned                   results_seen = 0;
	bit                            quiet = 1'b0;

	sv39_page_table_map_and_walk dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Reset is applied once, at the start, and released on a rising edge.
	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Walk the shadow store for one word and apply its writes. A valid pointer is
	// followed only if it names a slot already taken under the current base; any other
	// pointer ends the walk, as a miss for a lookup and as out of tables for a map.
	// An invalid pointer ends a lookup and makes a map take the next fresh slot, if one is left.
	function automatic sv39_ptw_pkg::rsp_t walk_and_map(input sv39_ptw_pkg::req_t w);
		sv39_ptw_pkg::rsp_t              r;
		int unsigned                     slot;
		int unsigned                     at;
		logic [sv39_ptw_pkg::VPN_W-1:0]  idx;
		logic [sv39_ptw_pkg::ENT_W-1:0]  e;
		logic [sv39_ptw_pkg::PPN_W-1:0]  off;
		r.status = S_OK;
		r.entry = '0;
		slot = 0;
		for (int lv = 2; lv > 0; lv--) begin
			idx = sv39_ptw_pkg::VPN_W'(w.virt_addr >> (12 + 9 * lv));
			at = slot * sv39_ptw_pkg::ENTRIES_PER_TABLE + idx;
			e = shadow_store[at];
			if (e[0]) begin
				off = e[sv39_ptw_pkg::PPN_W+9:10] - base_ppn;
				if (off >= sv39_ptw_pkg::PPN_W'(slots_taken)) begin
					r.status = (w.action == A_MAP) ? S_FULL : S_MISS;
					return r;
				end
				slot = off[31:0];
			end else if (w.action == A_LOOKUP) begin
				r.status = S_MISS;
				return r;
			end else begin
				// Earlier links made by this same map stay in place on this exit.
				if (slots_taken >= sv39_ptw_pkg::NUM_TABLES) begin
					r.status = S_FULL;
					return r;
				end
				slot = slots_taken;
				slots_taken++;
				shadow_store[at] = {base_ppn + sv39_ptw_pkg::PPN_W'(slot), 10'd1};
			end
		end
		at = slot * sv39_ptw_pkg::ENTRIES_PER_TABLE + sv39_ptw_pkg::VPN_W'(w.virt_addr >> 12);
		if (w.action == A_MAP) begin
			shadow_store[at] = {w.phys_addr[sv39_ptw_pkg::PA_W-1:12], 2'b00,
				w.perm_flags | 8'h01};
		end
		r.entry = shadow_store[at];
		return r;
	endfunction

	// Random word. Most addresses are built from the index pools above; lookups often
	// revisit a page mapped earlier, and a few words use a fully random address so
	// that the table slots run out early and out-of-tables results keep coming.
	function automatic sv39_ptw_pkg::req_t random_word();
		sv39_ptw_pkg::req_t w;
		int unsigned        pick;
		int unsigned        k;
		w.action = 1'($urandom_range(0, 1));
		w.phys_addr = sv39_ptw_pkg::PA_W'({$urandom, $urandom});
		w.perm_flags = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (w.action == A_LOOKUP && mapped_va.size() != 0 && pick < 50) begin
			k = $urandom_range(0, mapped_va.size() - 1);
			w.virt_addr = {mapped_va[k][sv39_ptw_pkg::VA_W-1:12], 12'($urandom)};
		end else if (pick < 85) begin
			w.virt_addr = {ROOT_PICKS[$urandom_range(0, 5)], MID_PICKS[$urandom_range(0, 3)],
				9'($urandom), 12'($urandom)};
		end else begin
			w.virt_addr = sv39_ptw_pkg::VA_W'({$urandom, $urandom});
		end
		return w;
	endfunction

	// Offer one word and hold it until the engine takes it. Valid is left high after
	// the handshake; the next call or a base write decides whether it drops.
	task automatic put_word(input sv39_ptw_pkg::req_t w, input logic fixed,
		input sv39_ptw_pkg::rsp_t want);
		sv39_ptw_pkg::rsp_t got;
		while (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		got = walk_and_map(w);
		due_results.push_back(fixed ? want : got);
		if (w.action == A_MAP) begin
			mapped_va.push_back(w.virt_addr);
			if (mapped_va.size() > 128) void'(mapped_va.pop_front());
		end
	endtask

	// Base register writes happen only with the engine idle: every result returned,
	// then a short settle, then the write handshake itself.
	task automatic write_base(input logic [sv39_ptw_pkg::PPN_W-1:0] v);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		base_ppn = v;
	endtask

	// Result side. Ready drops now and then, never during the quiet phase, and once
	// for a long stretch so that the engine backs up and stops taking words.
	initial begin : receiver
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	// Every returned word is compared with the oldest one still due.
	always @(posedge clk) begin : check_results
		sv39_ptw_pkg::rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected result: status %0d entry %h",
						out_data.status, out_data.entry);
				end
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (out_data.status !== want.status || out_data.entry !== want.entry) begin
					if (mismatches < 10) begin
						$display("mismatch: status %0d entry %h, expected status %0d entry %h",
							out_data.status, out_data.entry, want.status, want.entry);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		sv39_ptw_pkg::rsp_t             want;
		sv39_ptw_pkg::rsp_t             none;
		sv39_ptw_pkg::req_t             w;
		logic [sv39_ptw_pkg::PPN_W-1:0] next_base;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		foreach (shadow_store[i]) shadow_store[i] = '0;
		slots_taken = 1;
		base_ppn = '0;
		none = '0;

		// Directed plan. The first half runs with base zero: misses on an empty store,
		// extreme addresses, physical addresses and flags, an invalid leaf read back
		// as stored, and ignored page-offset bits. Then the base moves to its top value
		// (new pointers wrap), to a value under which the old pointers name no taken
		// slot (lookup misses, map runs out of tables), and back to zero.
		plan = '{
			'{ROW_BASE, A_LOOKUP, 39'h0, 56'h0, 8'h00, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h0, 56'h0, 8'h00, 1'b1, S_MISS, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h7FFFFFFFFF, 56'h0, 8'h00, 1'b1, S_MISS, 54'h0},
			'{ROW_WORD, A_MAP, 39'h0, 56'hFFFFFFFFFFFFFF, 8'hFF, 1'b1, S_OK, 54'h3FFFFFFFFFFCFF},
			'{ROW_WORD, A_LOOKUP, 39'h0, 56'h0, 8'h00, 1'b1, S_OK, 54'h3FFFFFFFFFFCFF},
			'{ROW_WORD, A_LOOKUP, 39'h0000001FFF, 56'h0, 8'h00, 1'b1, S_OK, 54'h0},
			'{ROW_WORD, A_MAP, 39'h7FFFFFFFFF, 56'h0, 8'h00, 1'b1, S_OK, 54'h1},
			'{ROW_WORD, A_MAP, 39'h7FFFFFF000, 56'h00000000000FFF, 8'h00, 1'b1, S_OK, 54'h1},
			'{ROW_WORD, A_MAP, 39'h0000200000, 56'h55555555555555, 8'hAA, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_MAP, 39'h2AAAAAA000, 56'hAAAAAAAAAAAAAA, 8'h55, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h5555555000, 56'h0, 8'h00, 1'b0, S_OK, 54'h0},
			'{ROW_BASE, A_LOOKUP, 39'h0, 56'hFFFFFFFFFFF, 8'h00, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_MAP, 39'h4000000000, 56'h123456789AB000, 8'h0F, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h4000000000, 56'h0, 8'h00, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h0, 56'h0, 8'h00, 1'b0, S_OK, 54'h0},
			'{ROW_BASE, A_LOOKUP, 39'h0, 56'h100, 8'h00, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h0, 56'h0, 8'h00, 1'b1, S_MISS, 54'h0},
			'{ROW_WORD, A_MAP, 39'h0, 56'h0, 8'h00, 1'b1, S_FULL, 54'h0},
			'{ROW_WORD, A_MAP, 39'h1000000000, 56'h00000000001000, 8'hC3, 1'b0, S_OK, 54'h0},
			'{ROW_BASE, A_LOOKUP, 39'h0, 56'h0, 8'h00, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h0, 56'h0, 8'h00, 1'b1, S_OK, 54'h3FFFFFFFFFFCFF},
			'{ROW_WORD, A_MAP, 39'h0, 56'h0F0F0F0F0F0F0F, 8'h01, 1'b0, S_OK, 54'h0},
			'{ROW_WORD, A_LOOKUP, 39'h1000000000, 56'h0, 8'h00, 1'b0, S_OK, 54'h0}
		};

		while (arst_n !== 1'b1) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_BASE) begin
				write_base(plan[i].pa[sv39_ptw_pkg::PPN_W-1:0]);
			end else begin
				w.action = plan[i].act;
				w.virt_addr = plan[i].va;
				w.phys_addr = plan[i].pa;
				w.perm_flags = plan[i].flags;
				want.status = plan[i].st;
				want.entry = plan[i].ent;
				put_word(w, plan[i].fixed, want);
			end
		end

		// Random phases. Base zero keeps the pointers built so far usable; a random
		// base, the top value and a small offset make them stray or alias other slots.
		// The third phase runs with no idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1:       next_base = sv39_ptw_pkg::PPN_W'({$urandom, $urandom});
				3:       next_base = '1;
				5:       next_base = sv39_ptw_pkg::PPN_W'($urandom_range(1, 3));
				default: next_base = '0;
			endcase
			write_base(next_base);
			quiet = (ph == 2);
			repeat (ITEMS_PER_PHASE) put_word(random_word(), 1'b0, none);
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
